// ===== rtl/ddsr_pkg.sv =====
// Shared package for the degree-day snow, rain and runoff split block.
// Holds field widths, register indexes, reset values and rounding helpers.
// No dependencies.
`default_nettype none

package ddsr_pkg;

    localparam int unsigned HW = 21;
    localparam int unsigned CW = 17;
    localparam int unsigned TW = 16;

    typedef logic signed [HW-1:0] t_height;

    typedef enum logic [2:0] {
        REG_RAIN_RUNOFF_COEF  = 3'd0,
        REG_MELT_RUNOFF_COEF  = 3'd1,
        REG_GROUND_COEF       = 3'd2,
        REG_RAIN_ON_SNOW_COEF = 3'd3,
        REG_SNOW_ALL_TEMP     = 3'd4,
        REG_RAIN_ALL_TEMP     = 3'd5,
        REG_RAIN_SPAN_INVERSE = 3'd6,
        REG_FREEZING_TEMP     = 3'd7
    } t_reg_idx;

    localparam logic [CW-1:0] ONE16          = 17'd65536;
    localparam logic [14:0]   ONE14          = 15'd16384;
    localparam logic [TW-1:0] MIN_VALID_TEMP = 16'd12800;

    localparam logic [TW-1:0] RST_SNOW_ALL_TEMP     = 16'd34962;
    localparam logic [TW-1:0] RST_RAIN_ALL_TEMP     = 16'd35090;
    localparam logic [TW-1:0] RST_RAIN_SPAN_INVERSE = 16'd512;
    localparam logic [TW-1:0] RST_FREEZING_TEMP     = 16'd34963;

    localparam logic signed [63:0] HMAX64 = 64'sd1048575;
    localparam logic signed [63:0] HMIN64 = -64'sd1048576;

    function automatic logic [CW-1:0] clamp_coef(input logic [CW-1:0] c);
        return (c > ONE16) ? ONE16 : c;
    endfunction

    // Round the magnitude half up, then restore the sign.
    function automatic logic signed [63:0] rnd_s(input logic signed [63:0] x,
                                                 input int unsigned s);
        logic [63:0] ux;
        logic [63:0] m;
        ux = x;
        m = x[63] ? (~ux + 64'd1) : ux;
        m = (m + (64'd1 << (s - 1))) >> s;
        return x[63] ? $signed(~m + 64'd1) : $signed(m);
    endfunction

    function automatic t_height sat_h(input logic signed [63:0] x);
        if (x > HMAX64) begin
            return t_height'(HMAX64[HW-1:0]);
        end
        if (x < HMIN64) begin
            return t_height'(HMIN64[HW-1:0]);
        end
        return x[HW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/degree_day_snow_rain_runoff_split.sv =====
// Throughput: one request per cycle while the output is not stalled; the
// twelve stages each hold one request and move on their own, so empty stages
// fill while the output is stalled.
// Reset (synchronous, active low) empties every stage and loads the register
// reset values; the data registers are not reset.
// Top level of the snow, rain and runoff split; uses ddsr_pkg.
`default_nettype none

module degree_day_snow_rain_runoff_split (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [4:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [20:0]       i_precipitation,
    input  wire logic [15:0]              i_surface_temp,
    input  wire logic signed [15:0]       i_snow_fraction,
    input  wire logic signed [15:0]       i_melt_factor,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output ddsr_pkg::t_height             o_snow_melt,
    output ddsr_pkg::t_height             o_snow_accum,
    output ddsr_pkg::t_height             o_rain_runoff,
    output ddsr_pkg::t_height             o_melt_runoff,
    output ddsr_pkg::t_height             o_rain_ground,
    output ddsr_pkg::t_height             o_melt_ground,
    output logic                          o_all_valid
);

    localparam int unsigned NSTG = 12;

    logic [16:0] r_rain_runoff_coef;
    logic [16:0] r_melt_runoff_coef;
    logic [16:0] r_ground_coef;
    logic [16:0] r_rain_on_snow_coef;
    logic [15:0] r_snow_all_temp;
    logic [15:0] r_rain_all_temp;
    logic [15:0] r_rain_span_inverse;
    logic [15:0] r_freezing_temp;

    logic                 w_wr;
    ddsr_pkg::t_reg_idx   w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = ddsr_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rain_runoff_coef  <= '0;
            r_melt_runoff_coef  <= '0;
            r_ground_coef       <= '0;
            r_rain_on_snow_coef <= '0;
            r_snow_all_temp     <= ddsr_pkg::RST_SNOW_ALL_TEMP;
            r_rain_all_temp     <= ddsr_pkg::RST_RAIN_ALL_TEMP;
            r_rain_span_inverse <= ddsr_pkg::RST_RAIN_SPAN_INVERSE;
            r_freezing_temp     <= ddsr_pkg::RST_FREEZING_TEMP;
        end else if (w_wr) begin
            unique case (w_idx)
                ddsr_pkg::REG_RAIN_RUNOFF_COEF:  r_rain_runoff_coef  <= pwdata[16:0];
                ddsr_pkg::REG_MELT_RUNOFF_COEF:  r_melt_runoff_coef  <= pwdata[16:0];
                ddsr_pkg::REG_GROUND_COEF:       r_ground_coef       <= pwdata[16:0];
                ddsr_pkg::REG_RAIN_ON_SNOW_COEF: r_rain_on_snow_coef <= pwdata[16:0];
                ddsr_pkg::REG_SNOW_ALL_TEMP:     r_snow_all_temp     <= pwdata[15:0];
                ddsr_pkg::REG_RAIN_ALL_TEMP:     r_rain_all_temp     <= pwdata[15:0];
                ddsr_pkg::REG_RAIN_SPAN_INVERSE: r_rain_span_inverse <= pwdata[15:0];
                ddsr_pkg::REG_FREEZING_TEMP:     r_freezing_temp     <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            ddsr_pkg::REG_RAIN_RUNOFF_COEF:  prdata = {15'd0, r_rain_runoff_coef};
            ddsr_pkg::REG_MELT_RUNOFF_COEF:  prdata = {15'd0, r_melt_runoff_coef};
            ddsr_pkg::REG_GROUND_COEF:       prdata = {15'd0, r_ground_coef};
            ddsr_pkg::REG_RAIN_ON_SNOW_COEF: prdata = {15'd0, r_rain_on_snow_coef};
            ddsr_pkg::REG_SNOW_ALL_TEMP:     prdata = {16'd0, r_snow_all_temp};
            ddsr_pkg::REG_RAIN_ALL_TEMP:     prdata = {16'd0, r_rain_all_temp};
            ddsr_pkg::REG_RAIN_SPAN_INVERSE: prdata = {16'd0, r_rain_span_inverse};
            ddsr_pkg::REG_FREEZING_TEMP:     prdata = {16'd0, r_freezing_temp};
        endcase
    end

    logic [16:0] w_rc;
    logic [16:0] w_mc;
    logic [16:0] w_gc;
    logic [16:0] w_sc;

    assign w_rc = ddsr_pkg::clamp_coef(r_rain_runoff_coef);
    assign w_mc = ddsr_pkg::clamp_coef(r_melt_runoff_coef);
    assign w_gc = ddsr_pkg::clamp_coef(r_ground_coef);
    assign w_sc = ddsr_pkg::clamp_coef(r_rain_on_snow_coef);

    // Each stage takes a new request when it is empty or its content moves on.
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_take;
    logic [NSTG:1] w_vin;

    assign w_vin = {r_vld[NSTG-1:1], i_valid};

    always_comb begin
        w_take[NSTG] = !r_vld[NSTG] || !i_stall;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (w_take[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign o_stall = !w_take[1];
    assign o_valid = r_vld[NSTG];

    // Stage 1: validity, clamped fraction, temperature excess, first products.
    logic               w1_vp;
    logic               w1_vt;
    logic               w1_vs;
    logic [14:0]        w1_f;
    logic [15:0]        w1_dt;
    logic [15:0]        w1_tdiff;
    logic [31:0]        w1_ramp;
    logic signed [30:0] w1_mff;
    logic [31:0]        w1_scdt;

    always_comb begin
        w1_vp = !i_precipitation[20];
        w1_vt = i_surface_temp >= ddsr_pkg::MIN_VALID_TEMP;
        w1_vs = !i_snow_fraction[15];
        priority if (i_snow_fraction[15]) begin
            w1_f = '0;
        end else if (i_snow_fraction[14:0] > ddsr_pkg::ONE14) begin
            w1_f = ddsr_pkg::ONE14;
        end else begin
            w1_f = i_snow_fraction[14:0];
        end
        w1_dt    = (i_surface_temp >= r_freezing_temp) ? (i_surface_temp - r_freezing_temp)
                                                       : 16'd0;
        w1_tdiff = i_surface_temp - r_snow_all_temp;
        w1_ramp  = {16'd0, w1_tdiff} * {16'd0, r_rain_span_inverse};
        w1_mff   = i_melt_factor * $signed({1'b0, w1_f});
        w1_scdt  = {15'd0, w_sc} * {16'd0, w1_dt};
    end

    logic [19:0]        r1_p;
    logic               r1_vpt;
    logic               r1_vs;
    logic               r1_allv;
    logic [14:0]        r1_f;
    logic [15:0]        r1_dt;
    logic [31:0]        r1_ramp;
    logic               r1_gt_rain;
    logic               r1_gt_snow;
    logic signed [30:0] r1_mff;
    logic [31:0]        r1_scdt;

    always_ff @(posedge i_clk) begin
        if (w_take[1]) begin
            r1_p       <= i_precipitation[19:0];
            r1_vpt     <= w1_vp && w1_vt;
            r1_vs      <= w1_vs;
            r1_allv    <= w1_vp && w1_vt && w1_vs;
            r1_f       <= w1_f;
            r1_dt      <= w1_dt;
            r1_ramp    <= w1_ramp;
            r1_gt_rain <= i_surface_temp > r_rain_all_temp;
            r1_gt_snow <= i_surface_temp > r_snow_all_temp;
            r1_mff     <= w1_mff;
            r1_scdt    <= w1_scdt;
        end
    end

    // Stage 2: rain portion of the ramp and the two products that follow.
    logic [16:0] w2_r;

    always_comb begin
        priority if (r1_gt_rain) begin
            w2_r = ddsr_pkg::ONE16;
        end else if (r1_gt_snow) begin
            w2_r = (r1_ramp > {15'd0, ddsr_pkg::ONE16}) ? ddsr_pkg::ONE16 : r1_ramp[16:0];
        end else begin
            w2_r = '0;
        end
    end

    logic [19:0]        r2_p;
    logic               r2_vpt;
    logic               r2_vs;
    logic               r2_allv;
    logic [14:0]        r2_f;
    logic [31:0]        r2_scdt;
    logic [36:0]        r2_rain_prod;
    logic signed [47:0] r2_m1_prod;

    always_ff @(posedge i_clk) begin
        if (w_take[2]) begin
            r2_p         <= r1_p;
            r2_vpt       <= r1_vpt;
            r2_vs        <= r1_vs;
            r2_allv      <= r1_allv;
            r2_f         <= r1_f;
            r2_scdt      <= r1_scdt;
            r2_rain_prod <= {20'd0, w2_r} * {17'd0, r1_p};
            r2_m1_prod   <= r1_mff * $signed({1'b0, r1_dt});
        end
    end

    // Stage 3: rain, snowfall and degree-day melt.
    logic [36:0]        w3_rsum;
    logic [19:0]        w3_rain;
    logic signed [63:0] w3_m1;

    always_comb begin
        w3_rsum = r2_rain_prod + 37'd32768;
        w3_rain = r2_vpt ? w3_rsum[35:16] : 20'd0;
        w3_m1   = r2_vs ? ddsr_pkg::rnd_s(64'(r2_m1_prod), 21) : 64'sd0;
    end

    logic [19:0]        r3_rain;
    logic [19:0]        r3_accum;
    logic signed [25:0] r3_m1;
    logic               r3_vs;
    logic               r3_allv;
    logic [14:0]        r3_f;
    logic [31:0]        r3_scdt;

    always_ff @(posedge i_clk) begin
        if (w_take[3]) begin
            r3_rain  <= w3_rain;
            r3_accum <= r2_vpt ? (r2_p - w3_rain) : 20'd0;
            r3_m1    <= w3_m1[25:0];
            r3_vs    <= r2_vs;
            r3_allv  <= r2_allv;
            r3_f     <= r2_f;
            r3_scdt  <= r2_scdt;
        end
    end

    // Stage 4: rain-on-snow product.
    logic [34:0]        r4_ros_prod;
    logic [19:0]        r4_rain;
    logic [19:0]        r4_accum;
    logic signed [25:0] r4_m1;
    logic               r4_vs;
    logic               r4_allv;
    logic [31:0]        r4_scdt;

    always_ff @(posedge i_clk) begin
        if (w_take[4]) begin
            r4_ros_prod <= {15'd0, r3_rain} * {20'd0, r3_f};
            r4_rain     <= r3_rain;
            r4_accum    <= r3_accum;
            r4_m1       <= r3_m1;
            r4_vs       <= r3_vs;
            r4_allv     <= r3_allv;
            r4_scdt     <= r3_scdt;
        end
    end

    // Stage 5: rain on snow and snow-free rain.
    logic [34:0] w5_sum;
    logic [19:0] w5_ros;

    always_comb begin
        w5_sum = r4_ros_prod + 35'd8192;
        w5_ros = r4_vs ? w5_sum[33:14] : 20'd0;
    end

    logic [19:0]        r5_ros;
    logic [19:0]        r5_free;
    logic [19:0]        r5_rain;
    logic [19:0]        r5_accum;
    logic signed [25:0] r5_m1;
    logic               r5_allv;
    logic [31:0]        r5_scdt;

    always_ff @(posedge i_clk) begin
        if (w_take[5]) begin
            r5_ros   <= w5_ros;
            r5_free  <= r4_vs ? (r4_rain - w5_ros) : 20'd0;
            r5_rain  <= r4_vs ? r4_rain : 20'd0;
            r5_accum <= r4_accum;
            r5_m1    <= r4_m1;
            r5_allv  <= r4_allv;
            r5_scdt  <= r4_scdt;
        end
    end

    // Stage 6: runoff shares of rain and the rain-on-snow melt product.
    logic [36:0]        r6_prf;
    logic [36:0]        r6_pmr;
    logic [51:0]        r6_pm2;
    logic [19:0]        r6_rain;
    logic [19:0]        r6_accum;
    logic signed [25:0] r6_m1;
    logic               r6_allv;

    always_ff @(posedge i_clk) begin
        if (w_take[6]) begin
            r6_prf   <= {20'd0, w_rc} * {17'd0, r5_free};
            r6_pmr   <= {20'd0, w_mc} * {17'd0, r5_ros};
            r6_pm2   <= {20'd0, r5_scdt} * {32'd0, r5_ros};
            r6_rain  <= r5_rain;
            r6_accum <= r5_accum;
            r6_m1    <= r5_m1;
            r6_allv  <= r5_allv;
        end
    end

    // Stage 7: rain runoff and total melt.
    logic [36:0]        w7_s1;
    logic [36:0]        w7_s2;
    logic [52:0]        w7_s3;
    logic signed [31:0] w7_melt;

    always_comb begin
        w7_s1   = r6_prf + 37'd32768;
        w7_s2   = r6_pmr + 37'd32768;
        w7_s3   = {1'b0, r6_pm2} + 53'd4194304;
        w7_melt = 32'(r6_m1) + $signed({2'b00, w7_s3[52:23]});
    end

    logic [20:0]       r7_rrun;
    ddsr_pkg::t_height r7_melt;
    logic [19:0]       r7_rain;
    logic [19:0]       r7_accum;
    logic              r7_allv;

    always_ff @(posedge i_clk) begin
        if (w_take[7]) begin
            r7_rrun  <= w7_s1[36:16] + w7_s2[36:16];
            r7_melt  <= ddsr_pkg::sat_h(64'(w7_melt));
            r7_rain  <= r6_rain;
            r7_accum <= r6_accum;
            r7_allv  <= r6_allv;
        end
    end

    // Stage 8: rain left after runoff, melt runoff product.
    logic signed [21:0] r8_rdiff;
    logic signed [38:0] r8_pmm;
    ddsr_pkg::t_height  r8_melt;
    logic [20:0]        r8_rrun;
    logic [19:0]        r8_accum;
    logic               r8_allv;

    always_ff @(posedge i_clk) begin
        if (w_take[8]) begin
            r8_rdiff <= $signed({2'b00, r7_rain}) - $signed({1'b0, r7_rrun});
            r8_pmm   <= r7_melt * $signed({1'b0, w_mc});
            r8_melt  <= r7_melt;
            r8_rrun  <= r7_rrun;
            r8_accum <= r7_accum;
            r8_allv  <= r7_allv;
        end
    end

    // Stage 9: melt runoff, rain ground product.
    logic signed [63:0] w9_mrun;

    assign w9_mrun = ddsr_pkg::rnd_s(64'(r8_pmm), 16);

    logic signed [21:0] r9_mrun;
    logic signed [39:0] r9_prg;
    ddsr_pkg::t_height  r9_melt;
    logic [20:0]        r9_rrun;
    logic [19:0]        r9_accum;
    logic               r9_allv;

    always_ff @(posedge i_clk) begin
        if (w_take[9]) begin
            r9_mrun  <= w9_mrun[21:0];
            r9_prg   <= r8_rdiff * $signed({1'b0, w_gc});
            r9_melt  <= r8_melt;
            r9_rrun  <= r8_rrun;
            r9_accum <= r8_accum;
            r9_allv  <= r8_allv;
        end
    end

    // Stage 10: melt left after runoff, rain ground share.
    logic signed [63:0] w10_rgnd;

    assign w10_rgnd = ddsr_pkg::rnd_s(64'(r9_prg), 16);

    logic signed [22:0] r10_mdiff;
    logic signed [23:0] r10_rgnd;
    logic signed [21:0] r10_mrun;
    ddsr_pkg::t_height  r10_melt;
    logic [20:0]        r10_rrun;
    logic [19:0]        r10_accum;
    logic               r10_allv;

    always_ff @(posedge i_clk) begin
        if (w_take[10]) begin
            r10_mdiff <= 23'(r9_melt) - 23'(r9_mrun);
            r10_rgnd  <= w10_rgnd[23:0];
            r10_mrun  <= r9_mrun;
            r10_melt  <= r9_melt;
            r10_rrun  <= r9_rrun;
            r10_accum <= r9_accum;
            r10_allv  <= r9_allv;
        end
    end

    // Stage 11: melt ground product.
    logic signed [40:0] r11_pmg;
    logic signed [23:0] r11_rgnd;
    logic signed [21:0] r11_mrun;
    ddsr_pkg::t_height  r11_melt;
    logic [20:0]        r11_rrun;
    logic [19:0]        r11_accum;
    logic               r11_allv;

    always_ff @(posedge i_clk) begin
        if (w_take[11]) begin
            r11_pmg   <= r10_mdiff * $signed({1'b0, w_gc});
            r11_rgnd  <= r10_rgnd;
            r11_mrun  <= r10_mrun;
            r11_melt  <= r10_melt;
            r11_rrun  <= r10_rrun;
            r11_accum <= r10_accum;
            r11_allv  <= r10_allv;
        end
    end

    // Stage 12: melt ground share and saturation into the output register.
    logic signed [63:0] w12_mgnd;

    assign w12_mgnd = ddsr_pkg::rnd_s(64'(r11_pmg), 16);

    ddsr_pkg::t_height r_snow_melt;
    ddsr_pkg::t_height r_snow_accum;
    ddsr_pkg::t_height r_rain_runoff;
    ddsr_pkg::t_height r_melt_runoff;
    ddsr_pkg::t_height r_rain_ground;
    ddsr_pkg::t_height r_melt_ground;
    logic              r_all_valid;

    always_ff @(posedge i_clk) begin
        if (w_take[12]) begin
            r_snow_melt   <= r11_melt;
            r_snow_accum  <= $signed({1'b0, r11_accum});
            r_rain_runoff <= ddsr_pkg::sat_h($signed({43'd0, r11_rrun}));
            r_melt_runoff <= ddsr_pkg::sat_h(64'(r11_mrun));
            r_rain_ground <= ddsr_pkg::sat_h(64'(r11_rgnd));
            r_melt_ground <= ddsr_pkg::sat_h(w12_mgnd);
            r_all_valid   <= r11_allv;
        end
    end

    assign o_snow_melt   = r_snow_melt;
    assign o_snow_accum  = r_snow_accum;
    assign o_rain_runoff = r_rain_runoff;
    assign o_melt_runoff = r_melt_runoff;
    assign o_rain_ground = r_rain_ground;
    assign o_melt_ground = r_melt_ground;
    assign o_all_valid   = r_all_valid;

endmodule

`default_nettype wire

// ===== rtl/ddsr_checker.sv =====
// Port-level checks for the snow, rain and runoff split block, bound to its top level.
// Depends on ddsr_pkg and degree_day_snow_rain_runoff_split.
`default_nettype none

module ddsr_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire ddsr_pkg::t_height o_snow_melt,
    input wire ddsr_pkg::t_height o_snow_accum,
    input wire ddsr_pkg::t_height o_rain_runoff,
    input wire ddsr_pkg::t_height o_rain_ground
);

    localparam int unsigned SB = ddsr_pkg::HW - 1;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_snow_melt) && $stable(o_snow_accum))
        else $error("stalled result changed or vanished");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while the output moves");

    a_rain_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_snow_accum[SB] && !o_rain_runoff[SB] && !o_rain_ground[SB])
        else $error("snowfall or rain share came out negative");

endmodule

bind degree_day_snow_rain_runoff_split ddsr_checker u_ddsr_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for degree_day_snow_rain_runoff_split: directed and random cell requests are
// checked field by field against a predictor of the snow, rain and runoff split.
// Depends on ddsr_pkg and the block's RTL.

module tb;
    import ddsr_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned HOLD_OFF_CYCLES = 64;
    localparam int unsigned MAX_PRINTED = 40;
    localparam longint FULL_COVER = 16384;
    localparam longint UNIT_Q16 = 65536;
    localparam longint LOWEST_TEMP = 12800;

    typedef struct packed {
        logic signed [20:0] precipitation;
        logic        [15:0] surface_temp;
        logic signed [15:0] snow_fraction;
        logic signed [15:0] melt_factor;
    } t_cell_request;

    typedef struct packed {
        t_height snow_melt;
        t_height snow_accum;
        t_height rain_runoff;
        t_height melt_runoff;
        t_height rain_ground;
        t_height melt_ground;
        logic    all_valid;
    } t_cell_result;

    class runoff_scoreboard;
        t_cell_result  expected_q[$];
        int unsigned   mismatches;
        logic [CW-1:0] rain_share;
        logic [CW-1:0] melt_share;
        logic [CW-1:0] ground_share;
        logic [CW-1:0] ros_coef;
        logic [TW-1:0] snow_temp;
        logic [TW-1:0] rain_temp;
        logic [TW-1:0] span_inv;
        logic [TW-1:0] zero_c;

        function new();
            mismatches = 0;
            rain_share = '0;
            melt_share = '0;
            ground_share = '0;
            ros_coef = '0;
            snow_temp = RST_SNOW_ALL_TEMP;
            rain_temp = RST_RAIN_ALL_TEMP;
            span_inv = RST_RAIN_SPAN_INVERSE;
            zero_c = RST_FREEZING_TEMP;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_RAIN_RUNOFF_COEF:  rain_share = value[CW-1:0];
                REG_MELT_RUNOFF_COEF:  melt_share = value[CW-1:0];
                REG_GROUND_COEF:       ground_share = value[CW-1:0];
                REG_RAIN_ON_SNOW_COEF: ros_coef = value[CW-1:0];
                REG_SNOW_ALL_TEMP:     snow_temp = value[TW-1:0];
                REG_RAIN_ALL_TEMP:     rain_temp = value[TW-1:0];
                REG_RAIN_SPAN_INVERSE: span_inv = value[TW-1:0];
                REG_FREEZING_TEMP:     zero_c = value[TW-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Scale down with the magnitude rounded half up, then put the sign back.
        function longint round_shift(longint x, int unsigned sh);
            longint mag;
            mag = (x < 0) ? -x : x;
            mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
            return (x < 0) ? -mag : mag;
        endfunction

        function longint limit_coef(logic [CW-1:0] c);
            longint v;
            v = longint'(c);
            return (v > UNIT_Q16) ? UNIT_Q16 : v;
        endfunction

        function longint saturate(longint x);
            if (x > HMAX64) begin
                return HMAX64;
            end
            if (x < HMIN64) begin
                return HMIN64;
            end
            return x;
        endfunction

        function t_height clip_height(longint x);
            longint s;
            s = saturate(x);
            return s[HW-1:0];
        endfunction

        function t_cell_result predict(t_cell_request req);
            t_cell_result res;
            longint p, t, f, mf, portion, rain, accum, ros, free_rain, dt;
            longint melt, rrun, mrun, rgnd, mgnd, ramp;
            longint rc, mc, gc, sc, snow_t, rain_t, inv, frz;
            bit vp, vt, vs;
            p = longint'(req.precipitation);
            t = longint'(req.surface_temp);
            f = longint'(req.snow_fraction);
            mf = longint'(req.melt_factor);
            rc = limit_coef(rain_share);
            mc = limit_coef(melt_share);
            gc = limit_coef(ground_share);
            sc = limit_coef(ros_coef);
            snow_t = longint'(snow_temp);
            rain_t = longint'(rain_temp);
            inv = longint'(span_inv);
            frz = longint'(zero_c);
            vp = p >= 0;
            vt = t >= LOWEST_TEMP;
            vs = f >= 0;
            rain = 0;
            accum = 0;
            ros = 0;
            free_rain = 0;
            dt = 0;
            melt = 0;
            if (f > FULL_COVER) begin
                f = FULL_COVER;
            end
            if (t > rain_t) begin
                portion = UNIT_Q16;
            end else if (t > snow_t) begin
                ramp = (t - snow_t) * inv;
                portion = (ramp > UNIT_Q16) ? UNIT_Q16 : ramp;
            end else begin
                portion = 0;
            end
            if (vp && vt) begin
                rain = round_shift(portion * p, 16);
                accum = p - rain;
            end
            if (vs) begin
                ros = round_shift(rain * f, 14);
                free_rain = rain - ros;
            end
            if (t >= frz) begin
                dt = t - frz;
            end
            if (vs) begin
                melt = round_shift(mf * f * dt, 21);
            end
            melt = saturate(melt + round_shift(sc * dt * ros, 23));
            rrun = round_shift(rc * free_rain, 16) + round_shift(mc * ros, 16);
            mrun = round_shift(mc * melt, 16);
            rgnd = round_shift(gc * (free_rain + ros - rrun), 16);
            mgnd = round_shift(gc * (melt - mrun), 16);
            res.snow_melt = clip_height(melt);
            res.snow_accum = clip_height(accum);
            res.rain_runoff = clip_height(rrun);
            res.melt_runoff = clip_height(mrun);
            res.rain_ground = clip_height(rgnd);
            res.melt_ground = clip_height(mgnd);
            res.all_valid = vp && vt && vs;
            return res;
        endfunction

        function void note_request(t_cell_request req);
            expected_q = {expected_q, predict(req)};
        endfunction

        function void report(string msg);
            if (mismatches < MAX_PRINTED) begin
                $display("mismatch at %0t: %s", $time, msg);
            end
            mismatches++;
        endfunction

        function void compare_field(string field, longint got, longint want);
            if (got != want) begin
                report($sformatf("%s got %0d, expected %0d", field, got, want));
            end
        endfunction

        function void check_result(t_cell_result got);
            t_cell_result want;
            if (expected_q.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            compare_field("snow_melt", longint'(got.snow_melt), longint'(want.snow_melt));
            compare_field("snow_accum", longint'(got.snow_accum), longint'(want.snow_accum));
            compare_field("rain_runoff", longint'(got.rain_runoff),
                          longint'(want.rain_runoff));
            compare_field("melt_runoff", longint'(got.melt_runoff),
                          longint'(want.melt_runoff));
            compare_field("rain_ground", longint'(got.rain_ground),
                          longint'(want.rain_ground));
            compare_field("melt_ground", longint'(got.melt_ground),
                          longint'(want.melt_ground));
            compare_field("all_valid", longint'(got.all_valid), longint'(want.all_valid));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [20:0] i_precipitation = '0;
    logic [15:0]        i_surface_temp = '0;
    logic signed [15:0] i_snow_fraction = '0;
    logic signed [15:0] i_melt_factor = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    t_height            o_snow_melt;
    t_height            o_snow_accum;
    t_height            o_rain_runoff;
    t_height            o_melt_runoff;
    t_height            o_rain_ground;
    t_height            o_melt_ground;
    logic               o_all_valid;

    int unsigned send_idle_pct = 13;
    int unsigned stall_pct = 13;
    int unsigned hold_off_requests = 0;
    runoff_scoreboard sb = new();

    degree_day_snow_rain_runoff_split DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_precipitation(i_precipitation),
        .i_surface_temp(i_surface_temp),
        .i_snow_fraction(i_snow_fraction),
        .i_melt_factor(i_melt_factor),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_snow_melt(o_snow_melt),
        .o_snow_accum(o_snow_accum),
        .o_rain_runoff(o_rain_runoff),
        .o_melt_runoff(o_melt_runoff),
        .o_rain_ground(o_rain_ground),
        .o_melt_ground(o_melt_ground),
        .o_all_valid(o_all_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_request(t_cell_request'{i_precipitation, i_surface_temp,
                                            i_snow_fraction, i_melt_factor});
        end
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(t_cell_result'{o_snow_melt, o_snow_accum, o_rain_runoff,
                                           o_melt_runoff, o_rain_ground, o_melt_ground,
                                           o_all_valid});
        end
    end

    // The receiver owns its stall; a long hold-off is served here when one is requested.
    initial begin : receiver
        int unsigned served;
        int unsigned held;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (served != hold_off_requests) begin
                served++;
                i_stall <= 1'b1;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
                    @(posedge i_clk);
                end
            end else begin
                i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] rc, input logic [31:0] mc,
                                  input logic [31:0] gc, input logic [31:0] sc,
                                  input logic [31:0] snow_t, input logic [31:0] rain_t,
                                  input logic [31:0] inv, input logic [31:0] frz);
        write_reg(REG_RAIN_RUNOFF_COEF, rc);
        write_reg(REG_MELT_RUNOFF_COEF, mc);
        write_reg(REG_GROUND_COEF, gc);
        write_reg(REG_RAIN_ON_SNOW_COEF, sc);
        write_reg(REG_SNOW_ALL_TEMP, snow_t);
        write_reg(REG_RAIN_ALL_TEMP, rain_t);
        write_reg(REG_RAIN_SPAN_INVERSE, inv);
        write_reg(REG_FREEZING_TEMP, frz);
    endtask

    task automatic send_cell(input logic signed [20:0] p, input logic [15:0] t,
                             input logic signed [15:0] f, input logic signed [15:0] m);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_precipitation <= p;
        i_surface_temp <= t;
        i_snow_fraction <= f;
        i_melt_factor <= m;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Mostly plausible cells near the configured ramp and freezing point, the rest noise.
    task automatic send_random_cells(input int unsigned count);
        int unsigned        n;
        int                 lo;
        int                 hi;
        int                 a;
        int                 b;
        logic signed [20:0] p;
        logic [15:0]        t;
        logic signed [15:0] f;
        logic signed [15:0] m;
        for (n = 0; n < count; n++) begin
            p = 21'($urandom);
            t = 16'($urandom);
            f = 16'($urandom);
            m = 16'($urandom);
            if ($urandom_range(99) < 80) begin
                a = int'(sb.snow_temp);
                b = int'(sb.rain_temp);
                lo = ((a < b) ? a : b) - 256;
                hi = ((a < b) ? b : a) + 256;
                if (lo < LOWEST_TEMP) begin
                    lo = int'(LOWEST_TEMP);
                end
                if (hi > 65535) begin
                    hi = 65535;
                end
                p = ($urandom_range(3) == 0) ? 21'($urandom_range(1048575))
                                             : 21'($urandom_range(8191));
                case ($urandom_range(3))
                    0, 1: t = 16'($urandom_range(hi, lo));
                    2: t = 16'($urandom_range(65535, int'(LOWEST_TEMP)));
                    default: t = sb.zero_c + 16'($urandom_range(2560));
                endcase
                case ($urandom_range(7))
                    0: f = 16'(FULL_COVER);
                    1: f = '0;
                    default: f = 16'($urandom_range(int'(FULL_COVER)));
                endcase
                m = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048));
            end
            send_cell(p, t, f, m);
        end
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_random_cells(60);
        wait_all_results();

        apply_settings(30000, 45000, 20000, 65536, 34700, 35400, 94, 34963);
        send_idle_pct = 0;
        stall_pct = 0;
        send_cell(21'sd25600, 16'd34963, 16'sd8192, 16'sd1024);
        send_cell(21'sd1048575, 16'd65535, 16'sd16384, 16'sd32767);
        send_cell(21'sd1048575, 16'd65535, 16'sd16384, -16'sd32768);
        send_cell(21'sd0, 16'd35000, 16'sd8192, 16'sd512);
        send_cell(-21'sd1, 16'd35000, 16'sd8192, 16'sd512);
        send_cell(-21'sd1048576, 16'd40000, 16'sd16384, 16'sd1024);
        send_cell(21'sd25600, 16'd12799, 16'sd8192, 16'sd512);
        send_cell(21'sd25600, 16'd12800, 16'sd8192, 16'sd512);
        send_cell(21'sd25600, 16'd0, 16'sd0, 16'sd0);
        send_cell(21'sd25600, 16'd34700, 16'sd8192, 16'sd512);
        send_cell(21'sd25600, 16'd34701, 16'sd8192, 16'sd512);
        send_cell(21'sd25600, 16'd35400, 16'sd8192, 16'sd512);
        send_cell(21'sd25600, 16'd35401, 16'sd8192, 16'sd512);
        send_cell(21'sd25600, 16'd36000, -16'sd1, 16'sd512);
        send_cell(21'sd25600, 16'd36000, -16'sd32768, 16'sd512);
        send_cell(21'sd25600, 16'd36000, 16'sd16385, 16'sd512);
        send_cell(21'sd25600, 16'd36000, 16'sd32767, 16'sd512);
        send_cell(21'sd25600, 16'd36000, 16'sd0, 16'sd512);
        send_cell(21'sd25600, 16'd34962, 16'sd16384, 16'sd512);
        send_cell(21'sd25600, 16'd36000, 16'sd16384, 16'sd0);
        send_cell(21'sd1048575, 16'd36000, 16'sd16384, 16'sd32767);
        send_cell(21'sd1, 16'd35050, 16'sd16383, -16'sd1);
        send_random_cells(100);
        send_idle_pct = 13;
        stall_pct = 13;
        send_random_cells(100);
        wait_all_results();

        apply_settings(131071, 131071, 131071, 131071, 65535, 65535, 65535, 65535);
        send_random_cells(100);
        wait_all_results();

        apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        send_random_cells(100);
        wait_all_results();

        // Rain temperature below snow temperature, coefficients at exactly one.
        apply_settings(65536, 65536, 65536, 65536, 36000, 34000, 65535, 34000);
        send_random_cells(120);
        wait_all_results();

        // Narrow span with a large inverse, so the ramp saturates early.
        apply_settings($urandom_range(131071), $urandom_range(131071),
                       $urandom_range(131071), $urandom_range(131071),
                       34900, 35100, $urandom_range(1024, 400), 34963);
        send_random_cells(60);
        hold_off_requests++;
        send_random_cells(50);
        wait_all_results();
        send_random_cells(60);
        wait_all_results();

        if (sb.mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
